/* sv/ahc_pkg.sv */
`default_nettype none
package ahc_pkg;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_TACK     = 3'd1,
    OP_ENGAGE   = 3'd2,
    OP_DISENG   = 3'd3,
    OP_SET_MODE = 3'd4,
    OP_WIND_TGT = 3'd5,
    OP_MANUAL   = 3'd6,
    OP_HDG_TGT  = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    REG_KP   = 3'd0,
    REG_KI   = 3'd1,
    REG_KD   = 3'd2,
    REG_SLEW = 3'd3,
    REG_EN   = 3'd4
  } reg_e;

  localparam logic [1:0] MODE_HDG  = 2'd0;
  localparam logic [1:0] MODE_WIND = 2'd1;
  localparam logic [1:0] MODE_NAV  = 2'd2;

  localparam int unsigned FULL_CIRCLE = 46080;
  localparam int unsigned HALF_CIRCLE = 23040;
  localparam logic signed [13:0] RUDDER_LIMIT = 14'sd4480;
  localparam logic signed [15:0] TACK_WINDOW = 16'sd1024;
  localparam logic signed [15:0] DEADBAND = 16'sd256;
  localparam logic signed [21:0] INTEG_LIMIT = 22'sd393216;
  localparam logic signed [16:0] WIND_LIMIT = 17'sd21760;
  localparam logic signed [16:0] MANUAL_THRESHOLD = 17'sd64;
  localparam logic [11:0] DT_DEFAULT = 12'd1092;
  localparam logic [11:0] DT_MAX = 12'd3277;
  localparam logic signed [17:0] DECAY_MUL = 18'sd58982;

  // Reduces x (at least -92160) to the range of a full circle.
  function automatic logic [15:0] mod_circle(input logic signed [20:0] x);
    logic signed [21:0] s;
    logic [21:0] y;
    s = {x[20], x} + 22'sd92160;
    y = unsigned'(s);
    for (int k = 0; k < 4; k++) begin
      if (y >= 22'(FULL_CIRCLE)) begin
        y = y - 22'(FULL_CIRCLE);
      end
    end
    return y[15:0];
  endfunction

  // Wraps an angle difference to -180 .. just under +180 degrees.
  function automatic logic signed [15:0] wrap_half(input logic signed [20:0] x);
    logic signed [16:0] m;
    logic signed [16:0] r;
    m = signed'({1'b0, mod_circle(x + 21'sd23040)});
    r = m - 17'sd23040;
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

/* sv/autopilot_helm_controller_core.sv */
// Channel   Direction  Contents
// s_axis    in         tuser: operation[2:0]; tdata: heading, apparent_wind, yaw_rate,
//                      true_wind_dir, dt, argument
// m_axis    out        tdata: rudder, autopilot_on, tacking, manual_helm, pilot_mode
// cfg       in         cfg_we_i, cfg_idx_i, cfg_data_i
//
// A tick with the autopilot steering runs S_PREP, S_INT, S_KP, S_KI, S_KD, S_WANT, S_LIM,
// S_SLEW, S_DONE; a tick under tack or manual helm runs S_PREP, S_LIM, S_SLEW, S_DONE, a
// tack that starts S_PREP, S_TDIR, S_DONE, and anything else S_DONE alone.
// The sequence is set by the single multiplier, used once per product under a sequencer.
// The block takes one item at a time and accepts the next one once the result is
// registered, even while that result still waits on the output.
// Reset is asynchronous and active low and restores every register at once.
`default_nettype none
module autopilot_helm_controller_core
  import ahc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // heading[15:0], apparent_wind[31:16], yaw_rate[47:32], true_wind_dir[63:48],
  // dt[79:64], argument[96:80], zero pad[103:97]
  input  wire logic [103:0] s_axis_tdata,
  // operation[2:0]
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // rudder[13:0], autopilot_on[14], tacking[15], manual_helm[16], pilot_mode[18:17],
  // zero pad[23:19]
  output logic [23:0]       m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [15:0]  cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_TDIR, S_INT, S_KP, S_KI, S_KD, S_WANT, S_LIM, S_SLEW, S_DONE
  } state_e;

  state_e state_q;
  logic [15:0] kp_q, ki_q, kd_q, slew_q;
  logic        en_q;
  logic signed [13:0] rudder_q, manual_q, want_q;
  logic signed [19:0] integ_q;
  logic        engaged_q, held_q, tack_q, tdir_q;
  logic [1:0]  mode_q;
  logic signed [15:0] wind_q;
  logic [15:0] hdg_tgt_q, tack_tgt_q;
  logic [15:0] hd_q, tw_q;
  logic signed [15:0] awa_q, yaw_q, err_q;
  logic [11:0] dtc_q;
  logic        is_tack_q, db_q;
  logic signed [38:0] p_q;
  logic signed [43:0] acc_q;
  logic        out_v_q;
  logic [23:0] out_q;

  logic [2:0]  in_op;
  logic [15:0] in_hd, in_tw, in_dt;
  logic signed [15:0] in_awa, in_yaw;
  logic signed [16:0] in_arg;
  assign in_op  = s_axis_tuser;
  assign in_hd  = s_axis_tdata[15:0];
  assign in_awa = signed'(s_axis_tdata[31:16]);
  assign in_yaw = signed'(s_axis_tdata[47:32]);
  assign in_tw  = s_axis_tdata[63:48];
  assign in_dt  = s_axis_tdata[79:64];
  assign in_arg = signed'(s_axis_tdata[96:80]);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  logic signed [20:0] mul_a;
  logic signed [17:0] mul_b;
  logic [19:0] integ_abs;
  assign integ_abs = integ_q[19] ? 20'(-integ_q) : 20'(integ_q);

  always_comb begin
    mul_a = 21'(err_q);
    mul_b = signed'({6'd0, dtc_q});
    case (state_q)
      S_INT: begin
        if (db_q) begin
          mul_a = signed'({1'b0, integ_abs});
          mul_b = DECAY_MUL;
        end
      end
      S_KP: begin
        mul_a = db_q ? 21'sd0 : 21'(err_q);
        mul_b = signed'({2'b0, kp_q});
      end
      S_KI: begin
        mul_a = 21'(integ_q);
        mul_b = signed'({2'b0, ki_q});
      end
      S_KD: begin
        mul_a = 21'(yaw_q);
        mul_b = signed'({2'b0, kd_q});
      end
      S_LIM: begin
        mul_a = signed'({5'd0, slew_q});
      end
      default: ;
    endcase
  end

  logic signed [43:0] p_ext;
  assign p_ext = {{5{p_q[38]}}, p_q};

  // Integrator update from the step or decay product.
  logic signed [22:0] decay_mag;
  logic signed [38:0] step_r;
  logic signed [21:0] integ_n, integ_c;
  always_comb begin
    decay_mag = p_q[38:16];
    step_r    = (p_q + 39'sd64) >>> 7;
    if (db_q) begin
      integ_n = integ_q[19] ? -22'(decay_mag) : 22'(decay_mag);
    end else begin
      integ_n = 22'(integ_q) + step_r[21:0];
    end
    if (integ_n > INTEG_LIMIT) integ_c = INTEG_LIMIT;
    else if (integ_n < -INTEG_LIMIT) integ_c = -INTEG_LIMIT;
    else integ_c = integ_n;
  end

  // Wanted rudder from the accumulated PID sum.
  logic signed [43:0] sum_w;
  logic signed [22:0] sh_w;
  logic signed [13:0] want_w;
  always_comb begin
    sum_w = acc_q + (p_ext <<< 9) + 44'sd1048576;
    sh_w  = sum_w[43:21];
    if (sh_w > 23'(RUDDER_LIMIT)) want_w = RUDDER_LIMIT;
    else if (sh_w < -23'(RUDDER_LIMIT)) want_w = -RUDDER_LIMIT;
    else want_w = sh_w[13:0];
  end

  // Slew limit.
  logic [27:0] lim;
  logic [28:0] lim_r;
  logic signed [14:0] rerr, rud_n;
  logic [13:0] rmag;
  always_comb begin
    lim   = p_q[27:0];
    lim_r = {1'b0, lim} + 29'd32768;
    rerr  = 15'(want_q) - 15'(rudder_q);
    rmag  = rerr[14] ? 14'(-rerr) : 14'(rerr);
    if ({rmag, 16'd0} <= {2'b0, lim}) rud_n = 15'(want_q);
    else if (rerr > 15'sd0) rud_n = 15'(rudder_q) + signed'({2'b0, lim_r[28:16]});
    else rud_n = 15'(rudder_q) - signed'({2'b0, lim_r[28:16]});
  end

  // Tick preparation: tack progress and control error.
  logic signed [15:0] terr, perr, tdir_err;
  logic [15:0] tgt_new;
  always_comb begin
    terr = wrap_half(21'(signed'({1'b0, tack_tgt_q})) - 21'(signed'({1'b0, hd_q})));
    if (mode_q == MODE_WIND) perr = wrap_half(21'(wind_q) - 21'(awa_q));
    else perr = wrap_half(21'(signed'({1'b0, hdg_tgt_q})) - 21'(signed'({1'b0, hd_q})));
    tgt_new = mod_circle(21'(signed'({1'b0, tw_q, 1'b0})) - 21'(signed'({1'b0, hd_q})));
    tdir_err = wrap_half(21'(signed'({1'b0, tack_tgt_q})) - 21'(signed'({1'b0, hd_q})));
  end

  logic signed [16:0] arg_wind;
  logic signed [16:0] arg_man;
  always_comb begin
    if (in_arg > WIND_LIMIT) arg_wind = WIND_LIMIT;
    else if (in_arg < -WIND_LIMIT) arg_wind = -WIND_LIMIT;
    else arg_wind = in_arg;
    if (in_arg > 17'(RUDDER_LIMIT)) arg_man = -17'(RUDDER_LIMIT);
    else if (in_arg < -17'(RUDDER_LIMIT)) arg_man = 17'(RUDDER_LIMIT);
    else arg_man = -in_arg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kp_q <= 16'd4096; ki_q <= 16'd1024; kd_q <= 16'd1024; slew_q <= 16'd7680;
      en_q <= 1'b0;
      rudder_q <= '0; manual_q <= '0; want_q <= '0; integ_q <= '0;
      engaged_q <= 1'b1; held_q <= 1'b0; tack_q <= 1'b0; tdir_q <= 1'b0;
      mode_q <= MODE_HDG; wind_q <= 16'sd5760; hdg_tgt_q <= 16'd11520;
      tack_tgt_q <= '0; hd_q <= '0; tw_q <= '0; awa_q <= '0; yaw_q <= '0;
      err_q <= '0; dtc_q <= '0; is_tack_q <= 1'b0; db_q <= 1'b0;
      p_q <= '0; acc_q <= '0; out_v_q <= 1'b0; out_q <= '0;
    end else begin
      p_q <= 39'(mul_a * mul_b);
      if (out_v_q && m_axis_tready && state_q != S_DONE) out_v_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KP:   kp_q <= cfg_data_i;
          REG_KI:   ki_q <= cfg_data_i;
          REG_KD:   kd_q <= cfg_data_i;
          REG_SLEW: slew_q <= cfg_data_i;
          REG_EN:   en_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            hd_q <= in_hd; tw_q <= in_tw; awa_q <= in_awa; yaw_q <= in_yaw;
            if (in_dt == 16'd0) dtc_q <= DT_DEFAULT;
            else if (in_dt > 16'(DT_MAX)) dtc_q <= DT_MAX;
            else dtc_q <= in_dt[11:0];
            is_tack_q <= (in_op == OP_TACK);
            if ((in_op == OP_TICK && en_q) || (in_op == OP_TACK && en_q && !tack_q)) begin
              state_q <= S_PREP;
            end else begin
              state_q <= S_DONE;
            end
            case (op_e'(in_op))
              OP_TICK, OP_TACK: ;
              OP_ENGAGE: begin
                engaged_q <= 1'b1; held_q <= 1'b0;
                rudder_q <= '0; manual_q <= '0; integ_q <= '0;
                if (in_arg != 17'sd0) begin
                  if (mode_q == MODE_WIND) wind_q <= in_awa;
                  else if (mode_q == MODE_HDG) hdg_tgt_q <= mod_circle(21'(signed'({1'b0, in_hd})));
                end
              end
              OP_DISENG: begin
                engaged_q <= 1'b0; held_q <= 1'b0; manual_q <= rudder_q;
              end
              OP_SET_MODE: begin
                if (in_arg >= 17'sd0 && in_arg <= 17'sd2 && in_arg[1:0] != mode_q) begin
                  mode_q <= in_arg[1:0];
                  integ_q <= '0;
                  if (engaged_q) begin
                    if (in_arg[1:0] == MODE_WIND) wind_q <= in_awa;
                    else if (in_arg[1:0] == MODE_HDG) hdg_tgt_q <= mod_circle(21'(signed'({1'b0, in_hd})));
                  end
                end
              end
              OP_WIND_TGT: begin
                mode_q <= MODE_WIND; wind_q <= arg_wind[15:0]; integ_q <= '0;
                if (!engaged_q) begin
                  engaged_q <= 1'b1; held_q <= 1'b0; rudder_q <= '0; manual_q <= '0;
                end
              end
              OP_MANUAL: begin
                manual_q <= arg_man[13:0];
                if ((in_arg > MANUAL_THRESHOLD || in_arg < -MANUAL_THRESHOLD) && engaged_q) begin
                  engaged_q <= 1'b0; held_q <= 1'b1;
                end
              end
              default: hdg_tgt_q <= mod_circle(21'(in_arg));
            endcase
          end
        end
        S_PREP: begin
          if (is_tack_q) begin
            tack_tgt_q <= tgt_new;
            tack_q <= 1'b1; engaged_q <= 1'b0; held_q <= 1'b0;
            state_q <= S_TDIR;
          end else if (tack_q) begin
            want_q <= tdir_q ? RUDDER_LIMIT : -RUDDER_LIMIT;
            if ((terr > -TACK_WINDOW && terr < TACK_WINDOW) ||
                (tdir_q ? (terr > 16'sd0) : (terr < 16'sd0))) begin
              tack_q <= 1'b0; engaged_q <= 1'b1; held_q <= 1'b0; integ_q <= '0;
              if (mode_q == MODE_WIND) wind_q <= -wind_q;
              else if (mode_q == MODE_HDG) hdg_tgt_q <= tack_tgt_q;
            end
            state_q <= S_LIM;
          end else if (engaged_q) begin
            err_q <= perr;
            db_q <= (perr > -DEADBAND && perr < DEADBAND);
            state_q <= S_INT;
          end else begin
            want_q <= manual_q;
            held_q <= (manual_q > 14'(MANUAL_THRESHOLD) || manual_q < -14'(MANUAL_THRESHOLD));
            state_q <= S_LIM;
          end
        end
        S_TDIR: begin
          tdir_q <= tdir_err[15];
          state_q <= S_DONE;
        end
        S_INT: state_q <= S_KP;
        S_KP: begin
          integ_q <= integ_c[19:0];
          state_q <= S_KI;
        end
        S_KI: begin
          acc_q <= -(p_ext <<< 9);
          state_q <= S_KD;
        end
        S_KD: begin
          acc_q <= acc_q - p_ext;
          state_q <= S_WANT;
        end
        S_WANT: begin
          want_q <= want_w;
          state_q <= S_LIM;
        end
        S_LIM: state_q <= S_SLEW;
        S_SLEW: begin
          rudder_q <= rud_n[13:0];
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_v_q || m_axis_tready) begin
            out_v_q <= 1'b1;
            out_q <= {5'd0, mode_q, held_q, tack_q, engaged_q, rudder_q};
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_rudder_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rudder_q <= RUDDER_LIMIT && rudder_q >= -RUDDER_LIMIT)
    else $error("rudder out of range");
  a_integ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    22'(integ_q) <= INTEG_LIMIT && 22'(integ_q) >= -INTEG_LIMIT)
    else $error("integrator out of range");
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while busy");
  a_held_not_engaged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q |-> !engaged_q)
    else $error("manual helm held while engaged");

endmodule
`default_nettype wire
